/* design/shelf_rectangle_packer_unit_defines.svh */
// Assertion macros for the shelf rectangle packer.
`ifndef SHELF_RECTANGLE_PACKER_UNIT_DEFINES_SVH
`define SHELF_RECTANGLE_PACKER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SRP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SRP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/srp_pkg.sv */
// Types and constants shared by the shelf rectangle packer modules.
package srp_pkg;

    localparam int DIM_BITS   = 13;
    localparam int DIM_W      = DIM_BITS + 1;
    localparam int CUR_W      = DIM_W + 1;
    localparam int SUM_W      = DIM_W + 3;
    localparam int PAD_W      = 8;
    localparam int PIDX_W     = 8;
    localparam int PAGES_W    = 9;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = DIM_W;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 80;

    localparam logic CMD_RESERVE = 1'b0;
    localparam logic CMD_CLEAR   = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_TOO_LARGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_PAGE   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_X       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_Y       = 2'd3;

    localparam logic [DIM_W-1:0] PAGE_DIM_RESET = 14'd2048;

    typedef struct packed {
        logic [DIM_W-1:0] page_width;
        logic [DIM_W-1:0] page_height;
        logic [PAD_W-1:0] pad_x;
        logic [PAD_W-1:0] pad_y;
    } cfg_t;

    typedef struct packed {
        logic [CUR_W-1:0] cursor_x;
        logic [CUR_W-1:0] cursor_y;
        logic [DIM_W-1:0] row_height;
    } cursor_t;

    // first member is the top of the word, so page_index lands in the low bits
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PAGES_W-1:0]  pages_in_use;
        logic                opened_page;
        logic [DIM_W-1:0]    placed_height;
        logic [DIM_W-1:0]    placed_width;
        logic [DIM_W-1:0]    pos_y;
        logic [DIM_W-1:0]    pos_x;
        logic [PIDX_W-1:0]   page_index;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

/* design/shelf_rectangle_packer_unit.sv */
// Shelf rectangle packer top level: config registers, packer state and output buffering.
// Next-fit shelf packer for atlas pages. Takes one transaction per clock while s_tready
// is high and registers its result; every request, including a clear, yields exactly
// one result. The rate is set by the cursor/row/page-count feedback loop, which is
// combinational and registered when a request commits. An output register backed by a
// skid stage lets a new request be taken while a result waits; s_tready drops only when
// both are full. The user must write configuration through cfg_wr_en/cfg_index/cfg_wdata
// only while no request is in flight; the block does not enforce this. PAGE_LIMIT sets
// the number of pages available before status reports out of pages.
`include "shelf_rectangle_packer_unit_defines.svh"

module shelf_rectangle_packer_unit #(
    parameter int PAGE_LIMIT = 256
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_wr_en,
    input  logic [srp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [srp_pkg::CFG_DATA_W-1:0]    cfg_wdata,

    input  logic                              s_tvalid,
    output logic                              s_tready,
    // req_width [13:0], req_height [27:14], zero [31:28]
    input  logic [srp_pkg::S_TDATA_W-1:0]     s_tdata,
    // command [0]
    input  logic                              s_tuser,

    output logic                              m_tvalid,
    input  logic                              m_tready,
    // page_index [7:0], pos_x [21:8], pos_y [35:22], placed_width [49:36],
    // placed_height [63:50], opened_page [64], pages_in_use [73:65],
    // status [75:74], zero [79:76]
    output logic [srp_pkg::M_TDATA_W-1:0]     m_tdata
);
    import srp_pkg::*;

    localparam int PCW = $clog2(PAGE_LIMIT + 1);

    cfg_t             cfg_reg;
    cursor_t          cursor_reg;
    cursor_t          cursor_next;
    logic [PCW-1:0]   page_count_reg;
    logic [PCW-1:0]   page_count_next;
    logic             commit;
    result_t          place_res;

    result_t          out_data_reg;
    logic             out_valid_reg;
    result_t          skid_data_reg;
    logic             skid_valid_reg;

    logic             push;
    logic             pop;

    assign s_tready = !skid_valid_reg;
    assign push     = s_tvalid && s_tready;
    assign pop      = out_valid_reg && m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - RESULT_W)'(0), out_data_reg};

    srp_place #(
        .PAGE_LIMIT (PAGE_LIMIT),
        .PCW        (PCW)
    ) u_place (
        .cfg             (cfg_reg),
        .cur             (cursor_reg),
        .page_count      (page_count_reg),
        .command         (s_tuser),
        .req_width       (s_tdata[DIM_W-1:0]),
        .req_height      (s_tdata[2*DIM_W-1:DIM_W]),
        .res             (place_res),
        .cursor_next     (cursor_next),
        .page_count_next (page_count_next),
        .commit          (commit)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.page_width  <= PAGE_DIM_RESET;
            cfg_reg.page_height <= PAGE_DIM_RESET;
            cfg_reg.pad_x       <= '0;
            cfg_reg.pad_y       <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_PAGE_WIDTH:  cfg_reg.page_width  <= cfg_wdata;
                CFG_PAGE_HEIGHT: cfg_reg.page_height <= cfg_wdata;
                CFG_PAD_X:       cfg_reg.pad_x       <= cfg_wdata[PAD_W-1:0];
                CFG_PAD_Y:       cfg_reg.pad_y       <= cfg_wdata[PAD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg     <= '0;
            page_count_reg <= '0;
        end else if (push && commit) begin
            cursor_reg     <= cursor_next;
            page_count_reg <= page_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!out_valid_reg || pop) begin
                if (skid_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg  <= push;
                end
            end else if (push) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
            end else if (push) begin
                out_data_reg <= place_res;
            end
        end else if (push) begin
            skid_data_reg <= place_res;
        end
    end

    `SRP_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid full with output empty")
    `SRP_ASSERT_NOW(a_page_bound, 1'b1, page_count_reg <= PCW'(PAGE_LIMIT), "page count past limit")
    `SRP_ASSERT_NEXT(a_clear_empties, push && (s_tuser == CMD_CLEAR), page_count_reg == '0, "clear left pages open")
    `SRP_ASSERT_NEXT(a_reject_holds, push && !commit, $stable(page_count_reg) && $stable(cursor_reg), "rejected request moved state")

endmodule

/* design/srp_place.sv */
// Placement logic: one request against the cursor state, giving the result and next state.
module srp_place #(
    parameter int PAGE_LIMIT = 256,
    parameter int PCW        = $clog2(PAGE_LIMIT + 1)
) (
    input  srp_pkg::cfg_t                   cfg,
    input  srp_pkg::cursor_t                cur,
    input  logic [PCW-1:0]                  page_count,
    input  logic                            command,
    input  logic [srp_pkg::DIM_W-1:0]       req_width,
    input  logic [srp_pkg::DIM_W-1:0]       req_height,
    output srp_pkg::result_t                res,
    output srp_pkg::cursor_t                cursor_next,
    output logic [PCW-1:0]                  page_count_next,
    output logic                            commit
);
    import srp_pkg::*;

    logic [SUM_W-1:0] end_x;
    logic [SUM_W-1:0] wrap_y;
    logic [SUM_W-1:0] y_sel;
    logic [SUM_W-1:0] end_y;
    logic [SUM_W-1:0] y_fin;
    logic [CUR_W-1:0] x_sel;
    logic [CUR_W-1:0] x_fin;
    logic [DIM_W-1:0] row_sel;
    logic [DIM_W-1:0] row_fin;
    logic [PCW-1:0]   pc_new;
    logic             too_big;
    logic             first;
    logic             wrap;
    logic             need_page;
    logic             full;
    logic             opened;

    always_comb begin
        too_big   = (req_width > cfg.page_width) || (req_height > cfg.page_height);
        first     = (page_count == '0);

        // end of row
        end_x     = SUM_W'(cur.cursor_x) + SUM_W'(req_width);
        wrap      = !first && (end_x > SUM_W'(cfg.page_width));
        wrap_y    = SUM_W'(cur.cursor_y) + SUM_W'(cur.row_height) + SUM_W'(cfg.pad_y);
        y_sel     = wrap ? wrap_y : SUM_W'(cur.cursor_y);
        x_sel     = wrap ? '0 : cur.cursor_x;
        row_sel   = wrap ? '0 : cur.row_height;

        // bottom of page
        end_y     = y_sel + SUM_W'(req_height);
        need_page = !first && (end_y > SUM_W'(cfg.page_height));
        full      = need_page && (page_count >= PCW'(PAGE_LIMIT));
        opened    = first || need_page;

        x_fin     = opened ? '0 : x_sel;
        y_fin     = opened ? '0 : y_sel;
        row_fin   = opened ? '0 : row_sel;
        pc_new    = opened ? page_count + PCW'(1) : page_count;

        res             = '0;
        cursor_next     = cur;
        page_count_next = page_count;
        commit          = 1'b0;

        if (command == CMD_CLEAR) begin
            cursor_next     = '0;
            page_count_next = '0;
            commit          = 1'b1;
        end else if (too_big) begin
            res.status       = STATUS_TOO_LARGE;
            res.pages_in_use = PAGES_W'(page_count);
        end else if (full) begin
            res.status       = STATUS_NO_PAGE;
            res.pages_in_use = PAGES_W'(page_count);
        end else begin
            commit                 = 1'b1;
            page_count_next        = pc_new;
            res.status             = STATUS_OK;
            res.page_index         = PIDX_W'(pc_new - PCW'(1));
            res.pos_x              = DIM_W'(x_fin);
            res.pos_y              = DIM_W'(y_fin);
            res.placed_width       = req_width;
            res.placed_height      = req_height;
            res.opened_page        = opened;
            res.pages_in_use       = PAGES_W'(pc_new);
            cursor_next.cursor_x   = CUR_W'(SUM_W'(x_fin) + SUM_W'(req_width)
                                            + SUM_W'(cfg.pad_x));
            cursor_next.cursor_y   = CUR_W'(y_fin);
            cursor_next.row_height = (row_fin > req_height) ? row_fin : req_height;
        end
    end

endmodule

/* tb/shelf_rectangle_packer_unit_test.sv */
// Self-checking testbench for the shelf rectangle packer: directed, page exhaustion and random runs.
module shelf_rectangle_packer_unit_test;
    import srp_pkg::*;

    localparam int PAGE_LIMIT  = 256;
    localparam int STALL_LIMIT = 2000;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // req_width [13:0], req_height [27:14], zero [31:28]
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    // command [0]
    logic                  s_tuser = 1'b0;

    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // page_index [7:0], pos_x [21:8], pos_y [35:22], placed_width [49:36],
    // placed_height [63:50], opened_page [64], pages_in_use [73:65],
    // status [75:74], zero [79:76]
    logic [M_TDATA_W-1:0]  m_tdata;

    shelf_rectangle_packer_unit #(.PAGE_LIMIT(PAGE_LIMIT)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    // shadow of the packer registers and state
    cfg_t             shadow_cfg;
    logic [CUR_W-1:0] cur_x, cur_y;
    logic [DIM_W-1:0] row_h;
    logic [PAGES_W-1:0] pages_open;

    result_t     pending_placements[$];
    result_t     got_res, want_res;
    int unsigned results_seen   = 0;
    int unsigned mismatches     = 0;
    int unsigned stalled_cycles = 0;

    bit          tx_steady = 1'b0;
    bit          rx_steady = 1'b0;
    int unsigned rx_hold   = 0;
    int unsigned rx_roll;

    initial begin
        shadow_cfg.page_width  = PAGE_DIM_RESET;
        shadow_cfg.page_height = PAGE_DIM_RESET;
        shadow_cfg.pad_x       = '0;
        shadow_cfg.pad_y       = '0;
        cur_x      = '0;
        cur_y      = '0;
        row_h      = '0;
        pages_open = '0;
    end

    function automatic result_t place_rect(logic cmd, int unsigned w, int unsigned h);
        result_t     r;
        int unsigned x, y, row;
        bit          opened;
        r = '0;
        opened = 1'b0;
        if (cmd == CMD_CLEAR) begin
            cur_x      = '0;
            cur_y      = '0;
            row_h      = '0;
            pages_open = '0;
            return r;
        end
        if (w > shadow_cfg.page_width || h > shadow_cfg.page_height) begin
            r.pages_in_use = pages_open;
            r.status       = STATUS_TOO_LARGE;
            return r;
        end
        x   = cur_x;
        y   = cur_y;
        row = row_h;
        if (pages_open == 0) begin
            opened = 1'b1;
            x = 0;
            y = 0;
            row = 0;
        end else begin
            if (x + w > shadow_cfg.page_width) begin
                x = 0;
                y = y + row + shadow_cfg.pad_y;
                row = 0;
            end
            if (y + h > shadow_cfg.page_height) begin
                // wrap is dropped too when no page is left
                if (pages_open >= PAGE_LIMIT) begin
                    r.pages_in_use = pages_open;
                    r.status       = STATUS_NO_PAGE;
                    return r;
                end
                opened = 1'b1;
                x = 0;
                y = 0;
                row = 0;
            end
        end
        if (opened)
            pages_open = pages_open + 1'b1;
        cur_x = CUR_W'(x + w + shadow_cfg.pad_x);
        cur_y = CUR_W'(y);
        row_h = DIM_W'((row > h) ? row : h);
        r.page_index    = PIDX_W'(pages_open - 1'b1);
        r.pos_x         = DIM_W'(x);
        r.pos_y         = DIM_W'(y);
        r.placed_width  = DIM_W'(w);
        r.placed_height = DIM_W'(h);
        r.opened_page   = opened;
        r.pages_in_use  = pages_open;
        r.status        = STATUS_OK;
        return r;
    endfunction

    task automatic report_error(string msg);
        $display("result %0d: %s", results_seen, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, int unsigned got, int unsigned want);
        if (got != want)
            report_error($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    // configuration shadow, prediction and result checking
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_PAGE_WIDTH:  shadow_cfg.page_width  = cfg_wdata;
                    CFG_PAGE_HEIGHT: shadow_cfg.page_height = cfg_wdata;
                    CFG_PAD_X:       shadow_cfg.pad_x       = cfg_wdata[PAD_W-1:0];
                    CFG_PAD_Y:       shadow_cfg.pad_y       = cfg_wdata[PAD_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                pending_placements.insert(pending_placements.size(),
                                          place_rect(s_tuser, s_tdata[DIM_W-1:0],
                                                     s_tdata[2*DIM_W-1:DIM_W]));
            if (m_tvalid && m_tready) begin
                if (pending_placements.size() == 0) begin
                    report_error("transaction with no request pending");
                end else begin
                    want_res = pending_placements.pop_front();
                    got_res  = result_t'(m_tdata[RESULT_W-1:0]);
                    check_field("padding", m_tdata[M_TDATA_W-1:RESULT_W], 0);
                    check_field("page_index", got_res.page_index, want_res.page_index);
                    check_field("pos_x", got_res.pos_x, want_res.pos_x);
                    check_field("pos_y", got_res.pos_y, want_res.pos_y);
                    check_field("placed_width", got_res.placed_width, want_res.placed_width);
                    check_field("placed_height", got_res.placed_height,
                                want_res.placed_height);
                    check_field("opened_page", got_res.opened_page, want_res.opened_page);
                    check_field("pages_in_use", got_res.pages_in_use, want_res.pages_in_use);
                    check_field("status", got_res.status, want_res.status);
                end
                results_seen++;
            end
        end
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
        end else if (rx_steady) begin
            m_tready <= 1'b1;
        end else begin
            rx_roll = $urandom_range(0, 99);
            if (rx_roll < 55) begin
                m_tready <= 1'b1;
                rx_hold  <= $urandom_range(0, 7);
            end else if (rx_roll < 95) begin
                m_tready <= 1'b0;
                rx_hold  <= $urandom_range(0, 2);
            end else begin
                m_tready <= 1'b0;
                rx_hold  <= $urandom_range(10, 40);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            stalled_cycles <= 0;
        end else if (stalled_cycles >= STALL_LIMIT) begin
            $display("shelf_rectangle_packer_unit_test NOT OK");
            $finish;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    task automatic send_request(logic cmd, int unsigned w, int unsigned h);
        int unsigned      gap;
        int unsigned      roll;
        logic [DIM_W-1:0] wv, hv;
        gap = 0;
        wv  = DIM_W'(w);
        hv  = DIM_W'(h);
        if (!tx_steady) begin
            roll = $urandom_range(0, 99);
            if (roll >= 95)
                gap = $urandom_range(10, 30);
            else if (roll >= 65)
                gap = $urandom_range(1, 3);
        end
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(S_TDATA_W-2*DIM_W){1'b0}}, hv, wv};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_placements.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_config(int unsigned pw, int unsigned ph, int unsigned px,
                                int unsigned py);
        wait_for_results();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_PAGE_WIDTH;
        cfg_wdata <= CFG_DATA_W'(pw);
        @(posedge aclk);
        cfg_index <= CFG_PAGE_HEIGHT;
        cfg_wdata <= CFG_DATA_W'(ph);
        @(posedge aclk);
        cfg_index <= CFG_PAD_X;
        cfg_wdata <= CFG_DATA_W'(px);
        @(posedge aclk);
        cfg_index <= CFG_PAD_Y;
        cfg_wdata <= CFG_DATA_W'(py);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic int unsigned pick_dim(int unsigned page_dim);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            return 0;
        if (roll < 13)
            return page_dim;
        if (roll < 18 && page_dim < 8192)
            return $urandom_range(page_dim + 1, 8192);
        if (roll < 25)
            return $urandom_range(page_dim / 2, page_dim);
        return $urandom_range(0, (page_dim + 3) / 4);
    endfunction

    // reset sizes: first page, exact fit, row wrap, new page, oversize, clear
    task automatic test_default_page();
        send_request(CMD_RESERVE, 0, 0);
        send_request(CMD_RESERVE, 2048, 100);
        send_request(CMD_RESERVE, 1, 50);
        send_request(CMD_RESERVE, 2048, 2048);
        send_request(CMD_RESERVE, 2049, 1);
        send_request(CMD_RESERVE, 1, 2049);
        send_request(CMD_RESERVE, 8192, 8192);
        send_request(CMD_RESERVE, 1, 1);
        send_request(CMD_CLEAR, 8192, 8192);
        send_request(CMD_RESERVE, 5, 7);
    endtask

    // largest page and padding; cursor left beyond the page
    task automatic test_padding_extremes();
        write_config(8192, 8192, 255, 255);
        send_request(CMD_RESERVE, 8192, 8192);
        send_request(CMD_RESERVE, 0, 0);
        send_request(CMD_RESERVE, 100, 100);
        send_request(CMD_RESERVE, 8000, 10);
        send_request(CMD_RESERVE, 8192, 1);
    endtask

    task automatic test_zero_page();
        write_config(0, 0, 3, 3);
        send_request(CMD_RESERVE, 0, 0);
        send_request(CMD_RESERVE, 1, 0);
        send_request(CMD_RESERVE, 0, 1);
        send_request(CMD_RESERVE, 0, 0);
        send_request(CMD_CLEAR, 0, 0);
    endtask

    // page shrinks under a cursor already in use
    task automatic test_resize_in_use();
        write_config(300, 300, 0, 0);
        send_request(CMD_RESERVE, 200, 200);
        write_config(100, 100, 0, 0);
        send_request(CMD_RESERVE, 50, 50);
    endtask

    task automatic test_page_exhaustion();
        write_config(1, 1, 0, 0);
        tx_steady = 1'b1;
        rx_steady <= 1'b1;
        send_request(CMD_CLEAR, 0, 0);
        repeat (PAGE_LIMIT) send_request(CMD_RESERVE, 1, 1);
        send_request(CMD_RESERVE, 1, 1);
        send_request(CMD_RESERVE, 2, 1);
        send_request(CMD_RESERVE, 0, 0);
        send_request(CMD_RESERVE, 1, 1);
        tx_steady = 1'b0;
        rx_steady <= 1'b0;
        send_request(CMD_CLEAR, 0, 0);
    endtask

    task automatic test_random_traffic();
        int unsigned pw, ph, px, py;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin pw = 2048; ph = 2048; px = 0; py = 0; end
                1: begin pw = 8192; ph = 8192; px = 255; py = 255; end
                2: begin
                    pw = $urandom_range(1, 64);
                    ph = $urandom_range(1, 64);
                    px = $urandom_range(0, 4);
                    py = $urandom_range(0, 4);
                end
                3: begin
                    pw = $urandom_range(1, 8192);
                    ph = $urandom_range(1, 8192);
                    px = $urandom_range(0, 255);
                    py = $urandom_range(0, 255);
                end
                4: begin pw = 1; ph = 8192; px = 0; py = 255; end
                default: begin pw = 64; ph = 64; px = 255; py = 0; end
            endcase
            write_config(pw, ph, px, py);
            tx_steady = (phase == 2);
            rx_steady <= (phase == 2);
            repeat (55) begin
                if ($urandom_range(0, 99) < 3)
                    send_request(CMD_CLEAR, $urandom_range(0, 8192), $urandom_range(0, 8192));
                else
                    send_request(CMD_RESERVE, pick_dim(pw), pick_dim(ph));
            end
        end
        tx_steady = 1'b0;
        rx_steady <= 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_default_page();
        test_padding_extremes();
        test_zero_page();
        test_resize_in_use();
        test_page_exhaustion();
        test_random_traffic();
        wait_for_results();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && pending_placements.size() == 0)
            $display("shelf_rectangle_packer_unit_test OK");
        else
            $display("shelf_rectangle_packer_unit_test NOT OK");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/srp_pkg.sv
design/srp_place.sv
design/shelf_rectangle_packer_unit.sv
tb/shelf_rectangle_packer_unit_test.sv
